// File: sv/dce_pkg.sv
`default_nettype none
package dce_pkg;

	localparam int SMP_W = 13;
	localparam int ACC_W = 48;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_I_OFFSET = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_Q_OFFSET = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_NULL_CODE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PRF = 3'd4;

	localparam logic signed [ACC_W-1:0] ACC_MAX = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [ACC_W-1:0] ACC_MIN = 48'sh8000_0000_0000;

	typedef enum logic [3:0] {
		ST_CLR,
		ST_IDLE,
		ST_SMUL,
		ST_SADD,
		ST_FRD,
		ST_FLD,
		ST_FCOR,
		ST_D1S,
		ST_D1W,
		ST_PROD,
		ST_D2S,
		ST_D2W,
		ST_EMIT
	} state_t;

	// arctangent of 2^-i in units of 2^-32 turn
	function automatic logic [31:0] atan_turn(input logic [4:0] idx);
		logic [31:0] r;
		case (idx)
			5'd0: r = 32'd536870912;
			5'd1: r = 32'd316933406;
			5'd2: r = 32'd167458907;
			5'd3: r = 32'd85004756;
			5'd4: r = 32'd42667331;
			5'd5: r = 32'd21354465;
			5'd6: r = 32'd10679838;
			5'd7: r = 32'd5340245;
			5'd8: r = 32'd2670163;
			5'd9: r = 32'd1335087;
			5'd10: r = 32'd667544;
			5'd11: r = 32'd333772;
			5'd12: r = 32'd166886;
			5'd13: r = 32'd83443;
			5'd14: r = 32'd41722;
			5'd15: r = 32'd20861;
			5'd16: r = 32'd10430;
			5'd17: r = 32'd5215;
			5'd18: r = 32'd2608;
			5'd19: r = 32'd1304;
			5'd20: r = 32'd652;
			5'd21: r = 32'd326;
			5'd22: r = 32'd163;
			5'd23: r = 32'd81;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// File: sv/doppler_centroid_estimator.sv
`default_nettype none
// Doppler centroid estimator. Echo samples (tuser = 0, tdata = i_raw, q_raw)
// are taken one at a time and each is handled in turn: read the line store and
// the per-bin accumulator memory, form conj(previous) * current, then add
// with saturation and write back. A finish item (tuser = 1) walks the bins:
// each of the n active bins goes through the shared iterative CORDIC, the
// remaining MAX_SAMPLES - n bins are zeroed at one per cycle, and two serial
// divisions finish the estimate, which then waits in the output register
// for its transfer. After reset the accumulator memory is swept to zero, one
// entry per cycle, before the first item is taken; configuration writes are
// taken at any time but must only be issued while the block is idle.
module doppler_centroid_estimator #(
	parameter int MAX_SAMPLES = 8192,
	parameter int ANGLE_ITERATIONS = 16
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_axis_tvalid,
	output logic                                    s_axis_tready,
	input  wire logic [15:0]                        s_axis_tdata, // i_raw, q_raw
	input  wire logic [0:0]                         s_axis_tuser, // kind
	output logic                                    m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	output logic [39:0]                             m_axis_tdata, // doppler_millihertz, mean_phase
	input  wire logic                               cfg_wen,
	input  wire logic [dce_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [dce_pkg::CFG_DATA_W-1:0]     cfg_data
);
	localparam int IDX_W = $clog2(MAX_SAMPLES);
	localparam int CNT_W = IDX_W + 1;
	localparam int CMP_W = (CNT_W > 14) ? CNT_W : 14;
	localparam int PS_W = 16 + IDX_W;
	localparam int PR_W = PS_W + 24;
	localparam int PM_W = PS_W + 25;
	localparam int DIV_W = PS_W + 9;
	localparam int SW = dce_pkg::SMP_W;
	localparam int AW = dce_pkg::ACC_W;

	dce_pkg::state_t state_q, state_d;

	// configuration registers
	logic [13:0] sample_count_q;
	logic [11:0] i_offset_q, q_offset_q;
	logic [7:0] null_code_q;
	logic [23:0] prf_q;

	// control state
	logic [IDX_W-1:0] col_q, k_q;
	logic [CNT_W-1:0] cnt_q, n_eff;
	logic primed_q, fin_q, neg_q;
	logic signed [PS_W-1:0] ps_q;

	// payload
	logic signed [SW-1:0] re_q, im_q;
	logic signed [SW*2:0] cr_q, ci_q;
	logic [PR_W-1:0] prod_q;
	logic signed [15:0] mean_q;
	logic signed [23:0] dop_q;
	logic m_valid_q;
	logic [39:0] m_data_q;

	// memories
	logic [2*SW-1:0] line_mem [MAX_SAMPLES];
	logic [2*AW-1:0] acc_mem [MAX_SAMPLES];
	logic [2*SW-1:0] line_rd_q;
	logic [2*AW-1:0] acc_rd_q;
	logic acc_we, rd_en;
	logic [IDX_W-1:0] acc_wa, rd_a;
	logic [2*AW-1:0] acc_wd;

	// datapath wires
	logic accept, is_fin, nul;
	logic [IDX_W-1:0] k_c;
	logic [CMP_W-1:0] sc_x;
	logic signed [SW-1:0] re_c, im_c, pr, pi;
	logic signed [SW*2:0] cr_c, ci_c;
	logic signed [AW:0] sr, si;
	logic signed [AW-1:0] sat_r, sat_i;
	logic [PS_W-1:0] mag_c;
	logic [PR_W-1:0] prod_c;
	logic [PM_W-1:0] t_c;
	logic [DIV_W-1:0] div_dvd, quo;
	logic div_start, div_done, cor_start, cor_done, emit;
	logic signed [15:0] cor_phase;

	// effective bin count, clamped to 1..MAX_SAMPLES
	always_comb begin
		sc_x = CMP_W'(sample_count_q);
		if (sc_x == '0) begin
			n_eff = CNT_W'(1);
		end else if (sc_x > CMP_W'(MAX_SAMPLES)) begin
			n_eff = CNT_W'(MAX_SAMPLES);
		end else begin
			n_eff = CNT_W'(sc_x);
		end
	end

	always_comb begin
		accept = s_axis_tvalid && s_axis_tready;
		is_fin = s_axis_tuser[0];
		nul = (s_axis_tdata[7:0] == null_code_q) || (s_axis_tdata[15:8] == null_code_q);
		re_c = nul ? '0 : $signed({1'b0, s_axis_tdata[7:0], 4'b0}) - $signed({1'b0, i_offset_q});
		im_c = nul ? '0 : $signed({1'b0, s_axis_tdata[15:8], 4'b0}) - $signed({1'b0, q_offset_q});
		k_c = ({1'b0, col_q} >= n_eff) ? '0 : col_q;
		pr = $signed(line_rd_q[SW-1:0]);
		pi = $signed(line_rd_q[2*SW-1:SW]);
		cr_c = (2*SW+1)'(pr * re_q) + (2*SW+1)'(pi * im_q);
		ci_c = (2*SW+1)'(pr * im_q) - (2*SW+1)'(pi * re_q);
		sr = (AW+1)'($signed(acc_rd_q[AW-1:0])) + (AW+1)'(cr_q);
		si = (AW+1)'($signed(acc_rd_q[2*AW-1:AW])) + (AW+1)'(ci_q);
		sat_r = (sr > (AW+1)'(dce_pkg::ACC_MAX)) ? dce_pkg::ACC_MAX :
			(sr < (AW+1)'(dce_pkg::ACC_MIN)) ? dce_pkg::ACC_MIN : sr[AW-1:0];
		sat_i = (si > (AW+1)'(dce_pkg::ACC_MAX)) ? dce_pkg::ACC_MAX :
			(si < (AW+1)'(dce_pkg::ACC_MIN)) ? dce_pkg::ACC_MIN : si[AW-1:0];
		mag_c = ps_q[PS_W-1] ? PS_W'(-ps_q) : PS_W'(ps_q);
		prod_c = mag_c * prf_q;
		t_c = PM_W'(prod_q) + PM_W'({n_eff, 15'b0});
	end

	// next state and strobes
	always_comb begin
		state_d = state_q;
		s_axis_tready = 1'b0;
		acc_we = 1'b0;
		acc_wa = cnt_q[IDX_W-1:0];
		acc_wd = '0;
		rd_en = 1'b0;
		rd_a = cnt_q[IDX_W-1:0];
		cor_start = 1'b0;
		div_start = 1'b0;
		div_dvd = DIV_W'(mag_c) + DIV_W'(n_eff >> 1);
		emit = 1'b0;
		case (state_q)
			dce_pkg::ST_CLR: begin
				acc_we = 1'b1;
				if (cnt_q == CNT_W'(MAX_SAMPLES - 1)) begin
					state_d = fin_q ? dce_pkg::ST_D1S : dce_pkg::ST_IDLE;
				end
			end
			dce_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				rd_a = k_c;
				if (accept) begin
					rd_en = !is_fin;
					state_d = is_fin ? dce_pkg::ST_FRD : dce_pkg::ST_SMUL;
				end
			end
			dce_pkg::ST_SMUL: state_d = dce_pkg::ST_SADD;
			dce_pkg::ST_SADD: begin
				acc_we = primed_q;
				acc_wa = k_q;
				acc_wd = {sat_i, sat_r};
				state_d = dce_pkg::ST_IDLE;
			end
			dce_pkg::ST_FRD: begin
				rd_en = 1'b1;
				state_d = dce_pkg::ST_FLD;
			end
			dce_pkg::ST_FLD: begin
				cor_start = 1'b1;
				acc_we = 1'b1;
				state_d = dce_pkg::ST_FCOR;
			end
			dce_pkg::ST_FCOR: begin
				if (cor_done) begin
					if (cnt_q == n_eff - 1'b1) begin
						state_d = (n_eff == CNT_W'(MAX_SAMPLES)) ? dce_pkg::ST_D1S : dce_pkg::ST_CLR;
					end else begin
						state_d = dce_pkg::ST_FRD;
					end
				end
			end
			dce_pkg::ST_D1S: begin
				div_start = 1'b1;
				state_d = dce_pkg::ST_D1W;
			end
			dce_pkg::ST_D1W: if (div_done) state_d = dce_pkg::ST_PROD;
			dce_pkg::ST_PROD: state_d = dce_pkg::ST_D2S;
			dce_pkg::ST_D2S: begin
				div_start = 1'b1;
				div_dvd = t_c[PM_W-1:16];
				state_d = dce_pkg::ST_D2W;
			end
			dce_pkg::ST_D2W: if (div_done) state_d = dce_pkg::ST_EMIT;
			dce_pkg::ST_EMIT: begin
				if (!m_valid_q || m_axis_tready) begin
					emit = 1'b1;
					state_d = dce_pkg::ST_IDLE;
				end
			end
			default: state_d = dce_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dce_pkg::ST_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q <= 14'd8192;
			i_offset_q <= 12'd248;
			q_offset_q <= 12'd248;
			null_code_q <= 8'd0;
			prf_q <= 24'd2000000;
		end else if (cfg_wen) begin
			case (cfg_index)
				dce_pkg::REG_SAMPLE_COUNT: sample_count_q <= cfg_data[13:0];
				dce_pkg::REG_I_OFFSET: i_offset_q <= cfg_data[11:0];
				dce_pkg::REG_Q_OFFSET: q_offset_q <= cfg_data[11:0];
				dce_pkg::REG_NULL_CODE: null_code_q <= cfg_data[7:0];
				dce_pkg::REG_PRF: prf_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// line position, bin walk and phase sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			cnt_q <= '0;
			primed_q <= 1'b0;
			fin_q <= 1'b0;
			ps_q <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (m_axis_tready && !emit) m_valid_q <= 1'b0;
			case (state_q)
				dce_pkg::ST_CLR: cnt_q <= cnt_q + 1'b1;
				dce_pkg::ST_IDLE: begin
					if (accept && is_fin) begin
						cnt_q <= '0;
						ps_q <= '0;
						fin_q <= 1'b1;
					end
				end
				dce_pkg::ST_SADD: begin
					// advance the column, wrap and prime at end of line
					if ({1'b0, k_q} + 1'b1 >= n_eff) begin
						col_q <= '0;
						primed_q <= 1'b1;
					end else begin
						col_q <= k_q + 1'b1;
					end
				end
				dce_pkg::ST_FCOR: begin
					if (cor_done) begin
						ps_q <= ps_q + PS_W'(cor_phase);
						cnt_q <= (cnt_q == n_eff - 1'b1) ? n_eff : cnt_q + 1'b1;
					end
				end
				dce_pkg::ST_EMIT: begin
					if (emit) begin
						m_valid_q <= 1'b1;
						ps_q <= '0;
						col_q <= '0;
						fin_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// sample and result payload
	always_ff @(posedge clk) begin
		if (state_q == dce_pkg::ST_IDLE && accept) begin
			re_q <= re_c;
			im_q <= im_c;
			k_q <= k_c;
		end
		if (state_q == dce_pkg::ST_SMUL) begin
			cr_q <= cr_c;
			ci_q <= ci_c;
		end
		if (state_q == dce_pkg::ST_D1S) neg_q <= ps_q[PS_W-1];
		if (state_q == dce_pkg::ST_D1W && div_done) begin
			mean_q <= neg_q ? -$signed(quo[15:0]) : $signed(quo[15:0]);
		end
		if (state_q == dce_pkg::ST_PROD) prod_q <= prod_c;
		if (state_q == dce_pkg::ST_D2W && div_done) begin
			if (!neg_q) begin
				dop_q <= (quo > DIV_W'(24'h7F_FFFF)) ? 24'sh7F_FFFF : $signed(quo[23:0]);
			end else begin
				dop_q <= (quo > DIV_W'(24'h80_0000)) ? 24'sh80_0000 : -$signed(quo[23:0]);
			end
		end
		if (emit) m_data_q <= {mean_q, dop_q};
	end

	// line store: written with the current sample once it has been read
	always_ff @(posedge clk) begin
		if (state_q == dce_pkg::ST_SMUL) line_mem[k_q] <= {im_q, re_q};
		if (rd_en) line_rd_q <= line_mem[rd_a];
	end

	// accumulator memory, {imag, real}
	always_ff @(posedge clk) begin
		if (acc_we) acc_mem[acc_wa] <= acc_wd;
		if (rd_en) acc_rd_q <= acc_mem[rd_a];
	end

	dce_cordic #(
		.ITER(ANGLE_ITERATIONS)
	) u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.start(cor_start),
		.x_in($signed(acc_rd_q[AW-1:0])),
		.y_in($signed(acc_rd_q[2*AW-1:AW])),
		.done(cor_done),
		.phase(cor_phase)
	);

	dce_div #(
		.DIV_W(DIV_W),
		.DEN_W(CNT_W)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(div_dvd),
		.divisor(n_eff),
		.done(div_done),
		.quotient(quo)
	);

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata = m_data_q;

`ifndef ASSERT_OFF
	a_cor_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		cor_done |-> state_q == dce_pkg::ST_FCOR)
		else $error("cordic result outside bin walk");
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == dce_pkg::ST_D1W || state_q == dce_pkg::ST_D2W))
		else $error("divider result outside division wait");
	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> (ps_q == '0 && col_q == '0))
		else $error("estimate emitted without clearing phase sum and column");
`endif

endmodule
`default_nettype wire

// File: sv/dce_cordic.sv
`default_nettype none
module dce_cordic #(
	parameter int ITER = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	input  wire logic signed [dce_pkg::ACC_W-1:0]    x_in,
	input  wire logic signed [dce_pkg::ACC_W-1:0]    y_in,
	output logic                                     done,
	output logic signed [15:0]                       phase
);
	localparam int IT_W = $clog2(ITER);
	localparam int CW = dce_pkg::ACC_W + 3;

	logic run_q, done_q, zero_q;
	logic [IT_W-1:0] it_q;
	logic signed [CW-1:0] x_q, y_q, xs, ys, xe, ye;
	logic [31:0] z_q, zr, at;

	always_comb begin
		xe = CW'(x_in);
		ye = CW'(y_in);
		xs = x_q >>> it_q;
		ys = y_q >>> it_q;
		at = dce_pkg::atan_turn(5'(it_q));
		zr = z_q + 32'h0000_8000;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			it_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				it_q <= '0;
			end else if (run_q) begin
				if (it_q == IT_W'(ITER - 1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
				it_q <= it_q + 1'b1;
			end
		end
	end

	// fold the left half plane, then rotate toward the x axis
	always_ff @(posedge clk) begin
		if (start) begin
			zero_q <= (x_in == '0) && (y_in == '0);
			if (x_in < 0) begin
				x_q <= -xe;
				y_q <= -ye;
				z_q <= 32'h8000_0000;
			end else begin
				x_q <= xe;
				y_q <= ye;
				z_q <= '0;
			end
		end else if (run_q) begin
			if (y_q >= 0) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end
		end
	end

	assign done = done_q;
	assign phase = zero_q ? 16'sd0 : $signed(zr[31:16]);

endmodule
`default_nettype wire

// File: sv/dce_div.sv
`default_nettype none
module dce_div #(
	parameter int DIV_W = 38,
	parameter int DEN_W = 14
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DIV_W-1:0] dividend,
	input  wire logic [DEN_W-1:0] divisor,
	output logic                  done,
	output logic [DIV_W-1:0]      quotient
);
	localparam int CT_W = $clog2(DIV_W + 1);

	logic run_q, done_q, ge;
	logic [CT_W-1:0] ct_q;
	logic [DIV_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q, den_q;
	logic [DEN_W:0] trial, diff;

	always_comb begin
		trial = {rem_q, quo_q[DIV_W-1]};
		ge = trial >= {1'b0, den_q};
		diff = trial - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			ct_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				ct_q <= '0;
			end else if (run_q) begin
				if (ct_q == CT_W'(DIV_W - 1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
				ct_q <= ct_q + 1'b1;
			end
		end
	end

	// one quotient bit per cycle, restoring
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (run_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

// File: tb/doppler_centroid_estimator_test.sv
`timescale 1ns / 100ps
module doppler_centroid_estimator_test;

	localparam int BINS = 8192;
	localparam int ITERS = 16;
	// Longest quiet stretch: a full-width finish walks every bin through the
	// CORDIC, and the post-reset clearing sweep comes before the first item.
	localparam int QUIET_LIMIT = 600000;
	localparam int ITEM_TARGET = 1850;
	// Largest line the store is primed with; later counts never exceed it,
	// so no unwritten store entry is ever read.
	localparam int PRIME_BINS = 96;

	// Tracks the estimator state and queues the estimates it should emit.
	class centroid_scoreboard;
		int unsigned bin_count_reg, i_off, q_off, null_byte, prf;
		int prev_i[BINS], prev_q[BINS];
		longint acc_re[BINS], acc_im[BINS];
		int unsigned column;
		bit primed;
		logic [39:0] estimates[$];
		int failures;
		int unsigned turn_step[24] = '{
			536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
			10679838, 5340245, 2670163, 1335087, 667544, 333772,
			166886, 83443, 41722, 20861, 10430, 5215,
			2608, 1304, 652, 326, 163, 81};

		function new();
			bin_count_reg = 8192; i_off = 248; q_off = 248; null_byte = 0;
			prf = 2000000; column = 0; primed = 0; failures = 0;
			foreach (prev_i[k]) begin
				prev_i[k] = 0; prev_q[k] = 0; acc_re[k] = 0; acc_im[k] = 0;
			end
		endfunction

		function void write_reg(logic [dce_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
			case (idx)
				dce_pkg::REG_SAMPLE_COUNT: bin_count_reg = val & 32'h3FFF;
				dce_pkg::REG_I_OFFSET: i_off = val & 32'hFFF;
				dce_pkg::REG_Q_OFFSET: q_off = val & 32'hFFF;
				dce_pkg::REG_NULL_CODE: null_byte = val & 32'hFF;
				dce_pkg::REG_PRF: prf = val & 32'hFF_FFFF;
				default: ;
			endcase
		endfunction

		function int unsigned active_bins();
			if (bin_count_reg < 1) return 1;
			if (bin_count_reg > BINS) return BINS;
			return bin_count_reg;
		endfunction

		function longint clip_acc(longint v);
			if (v > 64'sd140737488355327) return 64'sd140737488355327;
			if (v < -64'sd140737488355328) return -64'sd140737488355328;
			return v;
		endfunction

		// Vectoring CORDIC; angle kept in 2^-32 turn, rounded to 2^-16 turn.
		function int bin_phase(longint x, longint y);
			int unsigned z;
			longint xs, ys;
			logic [31:0] r;
			z = 0;
			if (x == 0 && y == 0) return 0;
			if (x < 0) begin
				x = -x; y = -y; z = 32'h8000_0000;
			end
			for (int i = 0; i < ITERS; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (y >= 0) begin
					x += ys; y -= xs; z += turn_step[i];
				end else begin
					x -= ys; y += xs; z -= turn_step[i];
				end
			end
			r = (z + 32'h8000) >> 16;
			return int'($signed(r[15:0]));
		endfunction

		function longint round_div(longint num, longint den);
			longint mag, q;
			mag = (num < 0) ? -num : num;
			q = (mag + den / 2) / den;
			return (num < 0) ? -q : q;
		endfunction

		function void note_transfer(bit finish, int unsigned ir, int unsigned qr);
			int unsigned n, k;
			int re, im;
			longint psum, mean, dop;
			n = active_bins();
			if (!finish) begin
				re = 0; im = 0;
				if (ir != null_byte && qr != null_byte) begin
					re = int'(ir * 16) - int'(i_off);
					im = int'(qr * 16) - int'(q_off);
				end
				if (column >= n) column = 0;
				k = column;
				if (primed) begin
					acc_re[k] = clip_acc(acc_re[k] + longint'(prev_i[k]) * re
						+ longint'(prev_q[k]) * im);
					acc_im[k] = clip_acc(acc_im[k] + longint'(prev_i[k]) * im
						- longint'(prev_q[k]) * re);
				end
				prev_i[k] = re; prev_q[k] = im;
				column++;
				if (column >= n) begin
					column = 0; primed = 1;
				end
				return;
			end
			psum = 0;
			for (k = 0; k < n; k++) psum += bin_phase(acc_re[k], acc_im[k]);
			mean = round_div(psum, n);
			dop = round_div(psum * longint'(prf), longint'(n) * 65536);
			if (dop > 8388607) dop = 8388607;
			if (dop < -8388608) dop = -8388608;
			estimates.push_back({mean[15:0], dop[23:0]});
			foreach (acc_re[j]) begin
				acc_re[j] = 0; acc_im[j] = 0;
			end
			column = 0;
		endfunction

		function void check_estimate(logic [39:0] got);
			logic [39:0] want;
			if (estimates.size() == 0) begin
				$display("%0t: unexpected estimate %h", $time, got);
				failures++;
				return;
			end
			want = estimates.pop_front();
			if (got[23:0] !== want[23:0]) begin
				$display("%0t: doppler_millihertz expected %0d actual %0d", $time,
					$signed(want[23:0]), $signed(got[23:0]));
				failures++;
			end
			if (got[39:24] !== want[39:24]) begin
				$display("%0t: mean_phase expected %0d actual %0d", $time,
					$signed(want[39:24]), $signed(got[39:24]));
				failures++;
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic s_axis_tvalid, s_axis_tready;
	logic [15:0] s_axis_tdata;  // i_raw, q_raw
	logic [0:0] s_axis_tuser;   // kind
	logic m_axis_tvalid, m_axis_tready;
	logic [39:0] m_axis_tdata;  // doppler_millihertz, mean_phase
	logic cfg_wen;
	logic [dce_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [dce_pkg::CFG_DATA_W-1:0] cfg_data;

	centroid_scoreboard sb;
	int items_sent;
	int burst_left;
	int quiet_cycles;
	int stall_mode;

	doppler_centroid_estimator uut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// Receiver: switch stall behavior at random, including a fully open mode.
	always @(negedge clk) begin
		if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
		case (stall_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= $urandom_range(0, 1);
			default: m_axis_tready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	// Check each result transfer; watch for a stalled run.
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) sb.check_estimate(m_axis_tdata);
		if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > QUIET_LIMIT) begin
			$display("doppler_centroid_estimator regression: fail");
			$finish;
		end
	end

	task automatic send(bit finish, int unsigned ir, int unsigned qr);
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {qr[7:0], ir[7:0]};
		s_axis_tuser <= finish;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_transfer(finish, ir, qr);
		items_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 3) != 0) begin
				@(negedge clk);
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(0, 6)) @(negedge clk);
			end
		end
	endtask

	// Echo sample with random content; sometimes hit the null code on one byte.
	task automatic send_echo();
		int unsigned ir, qr;
		ir = $urandom_range(0, 255);
		qr = $urandom_range(0, 255);
		case ($urandom_range(0, 11))
			0: ir = sb.null_byte;
			1: qr = sb.null_byte;
			2: begin ir = 0; qr = 255; end
			3: begin ir = 255; qr = 0; end
			default: ;
		endcase
		send(1'b0, ir, qr);
	endtask

	// Hold off until every estimate has come back, then let the block drain.
	task automatic settle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (sb.estimates.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic [dce_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[dce_pkg::CFG_DATA_W-1:0];
		sb.write_reg(idx, val);
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	function automatic int unsigned pick_offset();
		case ($urandom_range(0, 4))
			0: return 0;
			1: return 4095;
			2: return 248;
			default: return $urandom_range(0, 4095);
		endcase
	endfunction

	function automatic int unsigned pick_prf();
		case ($urandom_range(0, 4))
			0: return 1;
			1: return 16777215;
			2: return 2000000;
			default: return $urandom_range(1, 16777215);
		endcase
	endfunction

	initial begin
		int unsigned n, part;
		sb = new();
		items_sent = 0;
		burst_left = 8;
		stall_mode = 0;
		quiet_cycles = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		m_axis_tready = 1'b0;
		cfg_wen = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// Directed: out-of-range counts before any correlation return zeros.
		write_reg(dce_pkg::REG_SAMPLE_COUNT, 16383);
		send(1'b1, 0, 0);
		settle();
		write_reg(dce_pkg::REG_SAMPLE_COUNT, 0);
		send(1'b1, 255, 255);
		settle();

		// Prime the line store at its widest, with extreme settings.
		write_reg(dce_pkg::REG_SAMPLE_COUNT, PRIME_BINS);
		write_reg(dce_pkg::REG_I_OFFSET, 0);
		write_reg(dce_pkg::REG_Q_OFFSET, 4095);
		write_reg(dce_pkg::REG_NULL_CODE, 255);
		write_reg(dce_pkg::REG_PRF, 16777215);
		send(1'b0, 0, 0);
		send(1'b0, 255, 0);
		send(1'b0, 0, 254);
		send(1'b0, 254, 254);
		for (int k = 4; k < PRIME_BINS; k++) send_echo();
		send(1'b0, 0, 255);
		send(1'b0, 254, 0);
		send(1'b0, 0, 254);
		send(1'b0, 128, 7);
		for (int k = 4; k < PRIME_BINS; k++) send_echo();
		send(1'b1, 0, 0);
		settle();
		write_reg(dce_pkg::REG_PRF, 1);
		write_reg(dce_pkg::REG_NULL_CODE, 0);
		for (int k = 0; k < PRIME_BINS; k++) send_echo();
		send(1'b1, 0, 0);

		// Random phases: mostly complete lines then a finish.
		while (items_sent < ITEM_TARGET) begin
			settle();
			if ($urandom_range(0, 1)) write_reg(dce_pkg::REG_I_OFFSET, pick_offset());
			if ($urandom_range(0, 1)) write_reg(dce_pkg::REG_Q_OFFSET, pick_offset());
			if ($urandom_range(0, 2) == 0)
				write_reg(dce_pkg::REG_NULL_CODE,
					($urandom_range(0, 1)) ? $urandom_range(0, 255)
					: 255 * $urandom_range(0, 1));
			if ($urandom_range(0, 1)) write_reg(dce_pkg::REG_PRF, pick_prf());
			n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, PRIME_BINS)
				: $urandom_range(1, 24);
			write_reg(dce_pkg::REG_SAMPLE_COUNT, n);
			n = sb.active_bins();
			case ($urandom_range(0, 5))
				0: begin
					// Broken line: stop partway, then lower the count mid-line.
					part = $urandom_range(1, n);
					for (int k = 0; k < part; k++) send_echo();
					settle();
					write_reg(dce_pkg::REG_SAMPLE_COUNT, $urandom_range(1, part));
					n = sb.active_bins();
					repeat ($urandom_range(1, 3) * n) send_echo();
				end
				1: begin
					// Noise: a loose run of samples with no line structure.
					repeat ($urandom_range(0, 3 * n)) send_echo();
				end
				default: begin
					repeat ($urandom_range(1, 3) * n) send_echo();
				end
			endcase
			send(1'b1, $urandom_range(0, 255), $urandom_range(0, 255));
		end

		settle();
		if (sb.failures == 0)
			$display("doppler_centroid_estimator regression: pass");
		else
			$display("doppler_centroid_estimator regression: fail");
		$finish;
	end
endmodule
